// ===== src/ata_pio_disk_device_top_assert.svh =====
// Assertion macros for the ATA PIO disk device top level.
`ifndef ATA_PIO_DISK_DEVICE_TOP_ASSERT_SVH
`define ATA_PIO_DISK_DEVICE_TOP_ASSERT_SVH

// Check that cond holds in the same cycle as trig.
`define APDD_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Check that cond holds in the cycle after trig.
`define APDD_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== src/apdd_pkg.sv =====
// Shared constants, types and the IDENTIFY table for the ATA PIO disk device.
`default_nettype none

package apdd_pkg;

  localparam int DISK_SECTORS_DEF = 64;
  localparam int WORDS_PER_SECTOR = 256;
  localparam int WORD_W = 16;
  localparam int LBA_W = 28;
  localparam int CFG_DATA_W = 28;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_PRESENT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SECTORS = 1'd1;

  // Access kinds
  localparam logic FUNC_READ = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Task file offsets
  localparam logic [3:0] REG_DATA = 4'd0;
  localparam logic [3:0] REG_ERROR = 4'd1;
  localparam logic [3:0] REG_COUNT = 4'd2;
  localparam logic [3:0] REG_LBA_LOW = 4'd3;
  localparam logic [3:0] REG_LBA_MID = 4'd4;
  localparam logic [3:0] REG_LBA_HIGH = 4'd5;
  localparam logic [3:0] REG_DRIVE = 4'd6;
  localparam logic [3:0] REG_CMD = 4'd7;
  localparam logic [3:0] REG_CTRL = 4'd8;

  // Commands
  localparam logic [7:0] CMD_READ = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h30;
  localparam logic [7:0] CMD_FLUSH = 8'hE7;
  localparam logic [7:0] CMD_IDENTIFY = 8'hEC;

  // Status and error bits
  localparam logic [7:0] ST_BSY = 8'h80;
  localparam logic [7:0] ST_DRDY = 8'h40;
  localparam logic [7:0] ST_DRQ = 8'h08;
  localparam logic [7:0] ST_ERR = 8'h01;
  localparam logic [7:0] ERR_ABRT = 8'h04;
  localparam int CTRL_SRST_BIT = 2;

  // Task file reset values
  localparam logic [7:0] COUNT_RST = 8'h01;
  localparam logic [7:0] LBA_LOW_RST = 8'h01;
  localparam logic [7:0] DRIVE_RST = 8'hA0;
  localparam logic [LBA_W-1:0] TOTAL_SECTORS_RST = 28'd64;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_IDENT = 2'd1,
    MODE_READ  = 2'd2,
    MODE_WRITE = 2'd3
  } xfer_mode_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // IDENTIFY word: serial and model strings are spaces, words 60-61 the LBA28 total.
  function automatic logic [WORD_W-1:0] identify_word(input logic [7:0] w,
                                                       input logic [LBA_W-1:0] total);
    logic [WORD_W-1:0] v;
    v = '0;
    if ((w >= 8'd10 && w <= 8'd19) || (w >= 8'd27 && w <= 8'd46)) begin
      v = 16'h2020;
    end else if (w == 8'd60) begin
      v = total[15:0];
    end else if (w == 8'd61) begin
      v = {4'h0, total[27:16]};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/apdd_store.sv =====
// Sector store: single-port synchronous RAM with a registered read.
`default_nettype none

module apdd_store #(
  parameter int DEPTH = apdd_pkg::DISK_SECTORS_DEF * apdd_pkg::WORDS_PER_SECTOR,
  parameter int ADDR_W = 14
) (
  input  wire logic                        clk,
  input  wire apdd_pkg::mem_ctl_t          ctl,
  input  wire logic [ADDR_W-1:0]           addr,
  input  wire logic [apdd_pkg::WORD_W-1:0] wdata,
  output logic      [apdd_pkg::WORD_W-1:0] rdata
);

  logic [apdd_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/ata_pio_disk_device_top.sv =====
// ATA PIO disk device, LBA28 task file with a RAM-backed sector store.
//
// Usage:
//  - Slave stream s_*: one word per host register access. s_tdata carries the
//    16-bit write value, s_tuser the access kind and the register offset.
//  - Master stream m_*: one word per access with the read value and the status
//    byte that holds after the access.
//  - cfg_*: write-only port for device_present and total_sectors; write only
//    while no access is in flight.
// Timing: the accepting edge registers the word and the sector RAM read; the
// result is then registered into the output register from the pending word.
// A new word is taken as soon as the previous one has moved into the output
// register.
// Reset: rst (synchronous) restores the task file and config, then a clearing
// pass zeroes the sector RAM word by word, during which s_tready stays low.
// Stall: when m_tready is low the result holds in the output register; one
// more access may be taken and waits until the output register frees.
`default_nettype none

module ata_pio_disk_device_top #(
  parameter int DISK_SECTORS = apdd_pkg::DISK_SECTORS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [15:0]                     s_tdata,   // [15:0] wdata
  input  wire logic [4:0]                      s_tuser,   // [0] func, [4:1] reg_offset
  // Output stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [23:0]                     m_tdata,   // [15:0] rdata, [23:16] status_now
  // Configuration
  input  wire logic                            cfg_we,
  input  wire logic [apdd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [apdd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SECT_W = (DISK_SECTORS > 1) ? $clog2(DISK_SECTORS) : 1;
  localparam int ADDR_W = SECT_W + 8;
  localparam int MEM_DEPTH = DISK_SECTORS * apdd_pkg::WORDS_PER_SECTOR;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);
  localparam logic [28:0] DISK_LIMIT = 29'(DISK_SECTORS);

  // Configuration registers
  logic                          dev_present;
  logic [apdd_pkg::LBA_W-1:0]    total_sectors;

  // Task file and transfer state
  logic [7:0]                    count_reg, count_reg_next;
  logic [7:0]                    lba_low, lba_low_next;
  logic [7:0]                    lba_mid, lba_mid_next;
  logic [7:0]                    lba_high, lba_high_next;
  logic [7:0]                    drive_head, drive_head_next;
  logic [7:0]                    status_reg, status_reg_next;
  logic [7:0]                    error_reg, error_reg_next;
  apdd_pkg::xfer_mode_t          mode, mode_next;
  logic [7:0]                    word_index, word_index_next;
  logic [8:0]                    sectors_left, sectors_left_next;
  logic [apdd_pkg::LBA_W-1:0]    cur_lba, cur_lba_next;
  logic                          srst_held, srst_held_next;

  // Clearing pass and the pending access
  logic                          clearing;
  logic [ADDR_W-1:0]             clr_addr;
  logic                          pend;
  logic                          it_func;
  logic [3:0]                    it_reg;
  logic [apdd_pkg::WORD_W-1:0]   it_wdata;

  logic                          accept;
  logic                          process;
  logic [ADDR_W-1:0]             xfer_addr;
  logic [ADDR_W-1:0]             mem_addr;
  logic [apdd_pkg::WORD_W-1:0]   mem_wdata;
  logic [apdd_pkg::WORD_W-1:0]   mem_q;
  apdd_pkg::mem_ctl_t            mem_ctl;

  logic                          xfer_wr;
  logic [apdd_pkg::WORD_W-1:0]   rd_val;
  logic [7:0]                    status_out;

  logic [7:0]                    wbyte;
  logic [apdd_pkg::LBA_W-1:0]    cmd_lba;
  logic [8:0]                    cmd_cnt;
  logic [28:0]                   cmd_end;
  logic [28:0]                   limit;
  logic                          adv;
  logic [8:0]                    sl_dec;

  assign s_tready = !clearing && !pend;
  assign accept = s_tvalid && s_tready;
  assign process = pend && (!m_tvalid || m_tready);

  // Inside a transfer cur_lba is below DISK_SECTORS, so its low bits select the sector.
  assign xfer_addr = {cur_lba[SECT_W-1:0], word_index};
  assign mem_addr = clearing ? clr_addr : xfer_addr;
  assign mem_wdata = clearing ? '0 : it_wdata;
  assign mem_ctl.rd_en = accept;
  assign mem_ctl.wr_en = clearing || xfer_wr;

  apdd_store #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_q)
  );

  // Command operands
  assign wbyte = it_wdata[7:0];
  assign cmd_lba = {drive_head[3:0], lba_high, lba_mid, lba_low};
  assign cmd_cnt = (count_reg == 8'd0) ? 9'd256 : {1'b0, count_reg};
  assign cmd_end = {1'b0, cmd_lba} + 29'(cmd_cnt);
  assign limit = ({1'b0, total_sectors} < DISK_LIMIT) ? {1'b0, total_sectors} : DISK_LIMIT;
  assign sl_dec = (mode == apdd_pkg::MODE_IDENT) ? 9'd0 : sectors_left - 9'd1;

  // Access decode and state update for the pending word
  always_comb begin
    count_reg_next = count_reg;
    lba_low_next = lba_low;
    lba_mid_next = lba_mid;
    lba_high_next = lba_high;
    drive_head_next = drive_head;
    status_reg_next = status_reg;
    error_reg_next = error_reg;
    mode_next = mode;
    word_index_next = word_index;
    sectors_left_next = sectors_left;
    cur_lba_next = cur_lba;
    srst_held_next = srst_held;
    rd_val = '0;
    xfer_wr = 1'b0;
    adv = 1'b0;

    if (process && dev_present) begin
      if (it_func == apdd_pkg::FUNC_READ) begin
        unique case (it_reg)
          apdd_pkg::REG_DATA: begin
            if (!srst_held && mode == apdd_pkg::MODE_IDENT) begin
              rd_val = apdd_pkg::identify_word(word_index, total_sectors);
              adv = 1'b1;
            end else if (!srst_held && mode == apdd_pkg::MODE_READ) begin
              rd_val = mem_q;
              adv = 1'b1;
            end
          end
          apdd_pkg::REG_ERROR:    rd_val = {8'h00, error_reg};
          apdd_pkg::REG_COUNT:    rd_val = {8'h00, count_reg};
          apdd_pkg::REG_LBA_LOW:  rd_val = {8'h00, lba_low};
          apdd_pkg::REG_LBA_MID:  rd_val = {8'h00, lba_mid};
          apdd_pkg::REG_LBA_HIGH: rd_val = {8'h00, lba_high};
          apdd_pkg::REG_DRIVE:    rd_val = {8'h00, drive_head};
          apdd_pkg::REG_CMD,
          apdd_pkg::REG_CTRL:     rd_val = {8'h00, srst_held ? apdd_pkg::ST_BSY : status_reg};
          default:                rd_val = '0;
        endcase
      end else if (it_reg == apdd_pkg::REG_CTRL) begin
        if (wbyte[apdd_pkg::CTRL_SRST_BIT]) begin
          // Hold soft reset and drop any transfer
          srst_held_next = 1'b1;
          mode_next = apdd_pkg::MODE_IDLE;
          sectors_left_next = '0;
          word_index_next = '0;
        end else if (srst_held) begin
          // Release: task file back to reset values, store kept
          srst_held_next = 1'b0;
          count_reg_next = apdd_pkg::COUNT_RST;
          lba_low_next = apdd_pkg::LBA_LOW_RST;
          lba_mid_next = '0;
          lba_high_next = '0;
          drive_head_next = apdd_pkg::DRIVE_RST;
          status_reg_next = apdd_pkg::ST_DRDY;
          error_reg_next = '0;
          mode_next = apdd_pkg::MODE_IDLE;
          word_index_next = '0;
          sectors_left_next = '0;
          cur_lba_next = '0;
        end
      end else if (!srst_held) begin
        unique case (it_reg)
          apdd_pkg::REG_DATA: begin
            if (mode == apdd_pkg::MODE_WRITE) begin
              xfer_wr = 1'b1;
              adv = 1'b1;
            end
          end
          apdd_pkg::REG_COUNT:    count_reg_next = wbyte;
          apdd_pkg::REG_LBA_LOW:  lba_low_next = wbyte;
          apdd_pkg::REG_LBA_MID:  lba_mid_next = wbyte;
          apdd_pkg::REG_LBA_HIGH: lba_high_next = wbyte;
          apdd_pkg::REG_DRIVE:    drive_head_next = wbyte;
          apdd_pkg::REG_CMD: begin
            // A new command drops any running transfer
            mode_next = apdd_pkg::MODE_IDLE;
            word_index_next = '0;
            sectors_left_next = '0;
            priority case (1'b1)
              (wbyte == apdd_pkg::CMD_IDENTIFY): begin
                mode_next = apdd_pkg::MODE_IDENT;
                sectors_left_next = 9'd1;
                error_reg_next = '0;
                status_reg_next = apdd_pkg::ST_DRDY | apdd_pkg::ST_DRQ;
              end
              (wbyte == apdd_pkg::CMD_READ || wbyte == apdd_pkg::CMD_WRITE): begin
                if (cmd_end > limit) begin
                  error_reg_next = apdd_pkg::ERR_ABRT;
                  status_reg_next = apdd_pkg::ST_DRDY | apdd_pkg::ST_ERR;
                end else begin
                  mode_next = (wbyte == apdd_pkg::CMD_READ) ? apdd_pkg::MODE_READ
                                                            : apdd_pkg::MODE_WRITE;
                  cur_lba_next = cmd_lba;
                  sectors_left_next = cmd_cnt;
                  error_reg_next = '0;
                  status_reg_next = apdd_pkg::ST_DRDY | apdd_pkg::ST_DRQ;
                end
              end
              (wbyte == apdd_pkg::CMD_FLUSH): begin
                error_reg_next = '0;
                status_reg_next = apdd_pkg::ST_DRDY;
              end
              default: begin
                error_reg_next = apdd_pkg::ERR_ABRT;
                status_reg_next = apdd_pkg::ST_DRDY | apdd_pkg::ST_ERR;
              end
            endcase
          end
          default: ;
        endcase
      end

      // Advance the data pointer; close the sector and the command at its end
      if (adv) begin
        word_index_next = word_index + 8'd1;
        if (word_index == 8'hFF) begin
          sectors_left_next = sl_dec;
          if (mode != apdd_pkg::MODE_IDENT) begin
            cur_lba_next = cur_lba + 28'd1;
          end
          if (sl_dec == 9'd0) begin
            mode_next = apdd_pkg::MODE_IDLE;
            status_reg_next = apdd_pkg::ST_DRDY;
          end
        end
      end
    end

    if (!dev_present) begin
      status_out = '0;
    end else if (srst_held_next) begin
      status_out = apdd_pkg::ST_BSY;
    end else begin
      status_out = status_reg_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_present <= 1'b1;
      total_sectors <= apdd_pkg::TOTAL_SECTORS_RST;
    end else if (cfg_we) begin
      if (cfg_index == apdd_pkg::CFG_DEVICE_PRESENT) begin
        dev_present <= cfg_wdata[0];
      end else begin
        total_sectors <= cfg_wdata;
      end
    end
  end

  // Task file and transfer state
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= apdd_pkg::COUNT_RST;
      lba_low <= apdd_pkg::LBA_LOW_RST;
      lba_mid <= '0;
      lba_high <= '0;
      drive_head <= apdd_pkg::DRIVE_RST;
      status_reg <= apdd_pkg::ST_DRDY;
      error_reg <= '0;
      mode <= apdd_pkg::MODE_IDLE;
      word_index <= '0;
      sectors_left <= '0;
      cur_lba <= '0;
      srst_held <= 1'b0;
    end else begin
      count_reg <= count_reg_next;
      lba_low <= lba_low_next;
      lba_mid <= lba_mid_next;
      lba_high <= lba_high_next;
      drive_head <= drive_head_next;
      status_reg <= status_reg_next;
      error_reg <= error_reg_next;
      mode <= mode_next;
      word_index <= word_index_next;
      sectors_left <= sectors_left_next;
      cur_lba <= cur_lba_next;
      srst_held <= srst_held_next;
    end
  end

  // Clearing pass over the sector RAM after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  // Pending word: capture on accept, release when the result is registered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (process) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_func <= s_tuser[0];
      it_reg <= s_tuser[4:1];
      it_wdata <= s_tdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (process) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      m_tdata <= {status_out, rd_val};
    end
  end

  `include "ata_pio_disk_device_top_assert.svh"

  `APDD_ASSERT_NEXT(a_accept_pends, accept, pend && !s_tready,
                    "accepted word not held pending")
  `APDD_ASSERT_NOW(a_ram_one_access, mem_ctl.wr_en, !mem_ctl.rd_en,
                   "RAM read and write in one cycle")
  `APDD_ASSERT_NOW(a_xfer_drq, mode != apdd_pkg::MODE_IDLE,
                   status_reg == (apdd_pkg::ST_DRDY | apdd_pkg::ST_DRQ),
                   "transfer running without DRQ")
  `APDD_ASSERT_NOW(a_out_from_pend, $rose(m_tvalid), $past(pend),
                   "result without a pending word")

endmodule

`default_nettype wire
